[hw/rtl/rum_pkg.sv]
// Shared widths, word types and register indexes of the radial undistortion map.
package rum_pkg;

    // Fixed-point layout of the words.
    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 8;
    localparam int NORM_FRAC  = 28;
    localparam int CTR_W      = COORD_BITS + FRAC_BITS;
    localparam int FOC_W      = CTR_W + 4;
    localparam int MAP_W      = CTR_W + 3;
    localparam int COEFF_W    = 32;

    // Configuration port.
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;

    // Internal datapath widths.
    localparam int DX_W   = CTR_W + 1;
    localparam int QUO_W  = NORM_FRAC + 2;
    localparam int SQ_W   = 2 * QUO_W;
    localparam int R2_W   = 2 * QUO_W - NORM_FRAC;
    localparam int KR_W   = COEFF_W + R2_W;
    localparam int SC_W   = COEFF_W + R2_W - NORM_FRAC;
    localparam int PR_W   = DX_W + SC_W;
    localparam int OFF_W  = PR_W - NORM_FRAC;
    localparam int MV_W   = OFF_W + 1;

    // Register values after reset.
    localparam logic [CTR_W-1:0]          CENTER_X_RST = CTR_W'(81920);
    localparam logic [CTR_W-1:0]          CENTER_Y_RST = CTR_W'(61440);
    localparam logic [FOC_W-1:0]          FOCAL_X_RST  = FOC_W'(256000);
    localparam logic [FOC_W-1:0]          FOCAL_Y_RST  = FOC_W'(256000);
    localparam logic signed [COEFF_W-1:0] COEFF_RST    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = CFG_IDX_W'(0),
        CFG_CENTER_Y     = CFG_IDX_W'(1),
        CFG_FOCAL_X      = CFG_IDX_W'(2),
        CFG_FOCAL_Y      = CFG_IDX_W'(3),
        CFG_RADIAL_COEFF = CFG_IDX_W'(4)
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_in_word;

    typedef struct packed {
        logic signed [MAP_W-1:0] map_x;
        logic signed [MAP_W-1:0] map_y;
        logic                    saturated;
    } t_out_word;

endpackage

[hw/rtl/radial_undistort_map.sv]
// Top level of the radial undistortion map: a fully pipelined coordinate remap datapath.
// The normalization runs through a 30-stage restoring divider.
// Throughput: one word per cycle; a two-word output buffer keeps the pipeline moving while
// a result waits, and the input stalls only when both buffer words are held and a result
// arrives. Synchronous active-low reset empties the pipeline and the buffer and loads the
// register defaults; no result is produced while the coefficient register is zero.
module radial_undistort_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rum_pkg::t_in_word              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rum_pkg::t_out_word             o_out_data,
    input  logic                           i_cfg_wr,
    input  logic [rum_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rum_pkg::CFG_W-1:0]      i_cfg_data
);
    import rum_pkg::*;

    localparam int NDIV   = QUO_W;
    localparam int PRE_SH = QUO_W - NORM_FRAC;
    localparam int R2H    = R2_W / 2;
    localparam int KPL_W  = COEFF_W + R2H + 1;
    localparam int KPH_W  = COEFF_W + (R2_W - R2H) + 1;
    localparam int SPL    = SC_W / 2;
    localparam int ML_W   = DX_W + SPL + 1;
    localparam int MH_W   = DX_W + (SC_W - SPL);

    localparam logic [QUO_W-1:0]        NORM_MAX = QUO_W'(1) << (NORM_FRAC + 1);
    localparam logic signed [SC_W-1:0]  SC_ONE   = SC_W'(1) << NORM_FRAC;
    localparam logic signed [PR_W-1:0]  RND_HALF = PR_W'(1) << (NORM_FRAC - 1);
    localparam logic signed [MV_W-1:0]  MAP_HI   = MV_W'((1 << (MAP_W - 1)) - 1);
    localparam logic signed [MV_W-1:0]  MAP_LO   = ~MAP_HI;

    typedef struct packed {
        logic [FOC_W-1:0]        rem_x;
        logic [FOC_W-1:0]        rem_y;
        logic [QUO_W-1:0]        q_x;
        logic [QUO_W-1:0]        q_y;
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic                    ov_x;
        logic                    ov_y;
        logic                    fz;
    } t_div;

    function automatic logic [FOC_W-1:0] focal_mag(input logic [FOC_W-1:0] f);
        return f[FOC_W-1] ? FOC_W'(~f + 1'b1) : f;
    endfunction

    // One restoring division step per axis. The quotient register starts out holding the
    // low dividend bits, which shift out at the top while quotient bits shift in below.
    function automatic t_div div_step(input t_div s, input logic [FOC_W-1:0] dvx,
                                      input logic [FOC_W-1:0] dvy);
        t_div         o;
        logic [FOC_W:0] tx;
        logic [FOC_W:0] ty;
        o  = s;
        tx = {s.rem_x, s.q_x[QUO_W-1]};
        ty = {s.rem_y, s.q_y[QUO_W-1]};
        if (tx >= {1'b0, dvx}) begin
            o.rem_x = FOC_W'(tx - {1'b0, dvx});
            o.q_x   = {s.q_x[QUO_W-2:0], 1'b1};
        end else begin
            o.rem_x = FOC_W'(tx);
            o.q_x   = {s.q_x[QUO_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, dvy}) begin
            o.rem_y = FOC_W'(ty - {1'b0, dvy});
            o.q_y   = {s.q_y[QUO_W-2:0], 1'b1};
        end else begin
            o.rem_y = FOC_W'(ty);
            o.q_y   = {s.q_y[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Configuration registers; only focal magnitudes are kept since the sign never matters.
    logic [CTR_W-1:0]          r_center_x;
    logic [CTR_W-1:0]          r_center_y;
    logic [FOC_W-1:0]          r_fabs_x;
    logic [FOC_W-1:0]          r_fabs_y;
    logic signed [COEFF_W-1:0] r_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_fabs_x   <= FOCAL_X_RST;
            r_fabs_y   <= FOCAL_Y_RST;
            r_coeff    <= COEFF_RST;
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:     r_center_x <= i_cfg_data[CTR_W-1:0];
                CFG_CENTER_Y:     r_center_y <= i_cfg_data[CTR_W-1:0];
                CFG_FOCAL_X:      r_fabs_x   <= focal_mag(i_cfg_data[FOC_W-1:0]);
                CFG_FOCAL_Y:      r_fabs_y   <= focal_mag(i_cfg_data[FOC_W-1:0]);
                CFG_RADIAL_COEFF: r_coeff    <= $signed(i_cfg_data[COEFF_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Pipeline registers.
    logic                        r_e1_v, r_e2_v;
    logic signed [DX_W-1:0]      r_e1_dx, r_e1_dy, r_e2_dx, r_e2_dy;
    logic                        r_e1_fz, r_e2_fz;
    logic [CTR_W-1:0]            r_e2_ax, r_e2_ay;

    t_div                        r_div   [NDIV+1];
    logic                        r_div_v [NDIV+1];

    logic                        r_n1_v, r_n2_v, r_n3_v, r_n4_v, r_n5_v, r_n6_v;
    logic                        r_m1_v, r_m2_v;
    logic [QUO_W-1:0]            r_n1_nx, r_n1_ny;
    logic [SQ_W-1:0]             r_n2_sqx, r_n2_sqy;
    logic [R2_W-1:0]             r_n3_r2;
    logic signed [KPL_W-1:0]     r_n4_kpl;
    logic signed [KPH_W-1:0]     r_n4_kph;
    logic signed [KR_W-1:0]      r_n5_kr;
    logic signed [SC_W-1:0]      r_n6_scale;
    logic signed [DX_W-1:0]      r_n1_dx, r_n2_dx, r_n3_dx, r_n4_dx, r_n5_dx, r_n6_dx;
    logic signed [DX_W-1:0]      r_n1_dy, r_n2_dy, r_n3_dy, r_n4_dy, r_n5_dy, r_n6_dy;
    logic                        r_n1_fz, r_n2_fz, r_n3_fz, r_n4_fz, r_n5_fz, r_n6_fz;
    logic                        r_n1_sat, r_n2_sat, r_n3_sat, r_n4_sat, r_n5_sat, r_n6_sat;

    logic signed [ML_W-1:0]      r_m1_mxl, r_m1_myl;
    logic signed [MH_W-1:0]      r_m1_mxh, r_m1_myh;
    logic signed [PR_W-1:0]      r_m2_px, r_m2_py;
    logic                        r_m1_dxn, r_m1_dyn, r_m2_dxn, r_m2_dyn;
    logic                        r_m1_fz, r_m2_fz, r_m1_sat, r_m2_sat;

    // Output buffer.
    t_out_word                   r_ob [2];
    logic                        r_wp, r_rp;
    logic [1:0]                  r_cnt;

    logic                        w_adv;
    logic                        w_push;
    logic                        w_pop;
    logic                        n_e1_v;
    logic                        w_focal_zero;
    logic signed [DX_W-1:0]      n_e1_dx, n_e1_dy;
    logic [CTR_W-1:0]            n_e2_ax, n_e2_ay;
    t_div                        n_div0;
    logic                        n_n1_ovx, n_n1_ovy;
    logic [SQ_W:0]               w_r2_sum;
    logic signed [OFF_W-1:0]     w_off_x, w_off_y;
    logic signed [MV_W-1:0]      w_vx, w_vy;
    t_out_word                   w_res;

    // The pipeline moves unless the buffer is full and a result sits at its end.
    assign w_adv      = !((r_cnt == 2'd2) && r_m2_v);
    assign w_push     = w_adv && r_m2_v;
    assign w_pop      = (r_cnt != 2'd0) && !i_out_stall;
    assign o_in_stall = !w_adv;

    assign w_focal_zero = (r_fabs_x == '0) || (r_fabs_y == '0);
    assign n_e1_v  = i_in_valid && (r_coeff != '0);
    assign n_e1_dx = $signed({1'b0, i_in_data.pixel_x, {FRAC_BITS{1'b0}}})
                     - $signed({1'b0, r_center_x});
    assign n_e1_dy = $signed({1'b0, i_in_data.pixel_y, {FRAC_BITS{1'b0}}})
                     - $signed({1'b0, r_center_y});

    assign n_e2_ax = r_e1_dx[DX_W-1] ? CTR_W'(-r_e1_dx) : CTR_W'(r_e1_dx);
    assign n_e2_ay = r_e1_dy[DX_W-1] ? CTR_W'(-r_e1_dy) : CTR_W'(r_e1_dy);

    // A quotient that would not fit the divider is caught here and clipped later.
    always_comb begin
        n_div0.rem_x = FOC_W'(r_e2_ax >> PRE_SH);
        n_div0.rem_y = FOC_W'(r_e2_ay >> PRE_SH);
        n_div0.q_x   = QUO_W'({r_e2_ax, {NORM_FRAC{1'b0}}});
        n_div0.q_y   = QUO_W'({r_e2_ay, {NORM_FRAC{1'b0}}});
        n_div0.dx    = r_e2_dx;
        n_div0.dy    = r_e2_dy;
        n_div0.ov_x  = FOC_W'(r_e2_ax >> PRE_SH) >= r_fabs_x;
        n_div0.ov_y  = FOC_W'(r_e2_ay >> PRE_SH) >= r_fabs_y;
        n_div0.fz    = r_e2_fz;
    end

    assign n_n1_ovx = r_div[NDIV].ov_x || (r_div[NDIV].q_x > NORM_MAX);
    assign n_n1_ovy = r_div[NDIV].ov_y || (r_div[NDIV].q_y > NORM_MAX);
    assign w_r2_sum = {1'b0, r_n2_sqx} + {1'b0, r_n2_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                r_div_v[k] <= 1'b0;
            end
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
            r_n3_v <= 1'b0;
            r_n4_v <= 1'b0;
            r_n5_v <= 1'b0;
            r_n6_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (w_adv) begin
            r_e1_v     <= n_e1_v;
            r_e2_v     <= r_e1_v;
            r_div_v[0] <= r_e2_v;
            for (int k = 0; k < NDIV; k++) begin
                r_div_v[k+1] <= r_div_v[k];
            end
            r_n1_v <= r_div_v[NDIV];
            r_n2_v <= r_n1_v;
            r_n3_v <= r_n2_v;
            r_n4_v <= r_n3_v;
            r_n5_v <= r_n4_v;
            r_n6_v <= r_n5_v;
            r_m1_v <= r_n6_v;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1_dx <= n_e1_dx;
            r_e1_dy <= n_e1_dy;
            r_e1_fz <= w_focal_zero;

            r_e2_dx <= r_e1_dx;
            r_e2_dy <= r_e1_dy;
            r_e2_ax <= n_e2_ax;
            r_e2_ay <= n_e2_ay;
            r_e2_fz <= r_e1_fz;

            r_div[0] <= n_div0;
            for (int k = 0; k < NDIV; k++) begin
                r_div[k+1] <= div_step(r_div[k], r_fabs_x, r_fabs_y);
            end

            // Normalized coordinates above two are clipped to two.
            r_n1_nx  <= n_n1_ovx ? NORM_MAX : r_div[NDIV].q_x;
            r_n1_ny  <= n_n1_ovy ? NORM_MAX : r_div[NDIV].q_y;
            r_n1_sat <= n_n1_ovx || n_n1_ovy;
            r_n1_dx  <= r_div[NDIV].dx;
            r_n1_dy  <= r_div[NDIV].dy;
            r_n1_fz  <= r_div[NDIV].fz;

            r_n2_sqx <= SQ_W'(r_n1_nx) * SQ_W'(r_n1_nx);
            r_n2_sqy <= SQ_W'(r_n1_ny) * SQ_W'(r_n1_ny);
            r_n2_sat <= r_n1_sat;
            r_n2_dx  <= r_n1_dx;
            r_n2_dy  <= r_n1_dy;
            r_n2_fz  <= r_n1_fz;

            r_n3_r2  <= w_r2_sum[NORM_FRAC +: R2_W];
            r_n3_sat <= r_n2_sat;
            r_n3_dx  <= r_n2_dx;
            r_n3_dy  <= r_n2_dy;
            r_n3_fz  <= r_n2_fz;

            // The coefficient product is split into two halves of the squared radius.
            r_n4_kpl <= KPL_W'(r_coeff) * KPL_W'($signed({1'b0, r_n3_r2[R2H-1:0]}));
            r_n4_kph <= KPH_W'(r_coeff) * KPH_W'($signed({1'b0, r_n3_r2[R2_W-1:R2H]}));
            r_n4_sat <= r_n3_sat;
            r_n4_dx  <= r_n3_dx;
            r_n4_dy  <= r_n3_dy;
            r_n4_fz  <= r_n3_fz;

            r_n5_kr  <= (KR_W'(r_n4_kph) <<< R2H) + KR_W'(r_n4_kpl);
            r_n5_sat <= r_n4_sat;
            r_n5_dx  <= r_n4_dx;
            r_n5_dy  <= r_n4_dy;
            r_n5_fz  <= r_n4_fz;

            r_n6_scale <= SC_ONE - SC_W'(r_n5_kr >>> NORM_FRAC);
            r_n6_sat   <= r_n5_sat;
            r_n6_dx    <= r_n5_dx;
            r_n6_dy    <= r_n5_dy;
            r_n6_fz    <= r_n5_fz;

            r_m1_mxl <= ML_W'(r_n6_dx) * ML_W'($signed({1'b0, r_n6_scale[SPL-1:0]}));
            r_m1_myl <= ML_W'(r_n6_dy) * ML_W'($signed({1'b0, r_n6_scale[SPL-1:0]}));
            r_m1_mxh <= MH_W'(r_n6_dx) * MH_W'($signed(r_n6_scale[SC_W-1:SPL]));
            r_m1_myh <= MH_W'(r_n6_dy) * MH_W'($signed(r_n6_scale[SC_W-1:SPL]));
            r_m1_dxn <= r_n6_dx[DX_W-1];
            r_m1_dyn <= r_n6_dy[DX_W-1];
            r_m1_sat <= r_n6_sat;
            r_m1_fz  <= r_n6_fz;

            // Adding half before the floor shift rounds half up for either sign.
            r_m2_px  <= (PR_W'(r_m1_mxh) <<< SPL) + PR_W'(r_m1_mxl) + RND_HALF;
            r_m2_py  <= (PR_W'(r_m1_myh) <<< SPL) + PR_W'(r_m1_myl) + RND_HALF;
            r_m2_dxn <= r_m1_dxn;
            r_m2_dyn <= r_m1_dyn;
            r_m2_sat <= r_m1_sat;
            r_m2_fz  <= r_m1_fz;
        end
    end

    assign w_off_x = OFF_W'(r_m2_px >>> NORM_FRAC);
    assign w_off_y = OFF_W'(r_m2_py >>> NORM_FRAC);
    assign w_vx    = MV_W'($signed({1'b0, r_center_x})) + MV_W'(w_off_x);
    assign w_vy    = MV_W'($signed({1'b0, r_center_y})) + MV_W'(w_off_y);

    always_comb begin
        w_res.saturated = r_m2_sat;
        if (w_vx > MAP_HI) begin
            w_res.map_x     = MAP_W'(MAP_HI);
            w_res.saturated = 1'b1;
        end else if (w_vx < MAP_LO) begin
            w_res.map_x     = MAP_W'(MAP_LO);
            w_res.saturated = 1'b1;
        end else begin
            w_res.map_x = MAP_W'(w_vx);
        end
        if (w_vy > MAP_HI) begin
            w_res.map_y     = MAP_W'(MAP_HI);
            w_res.saturated = 1'b1;
        end else if (w_vy < MAP_LO) begin
            w_res.map_y     = MAP_W'(MAP_LO);
            w_res.saturated = 1'b1;
        end else begin
            w_res.map_y = MAP_W'(w_vy);
        end
        // A zero focal length drives both maps to the rail that their offset points to.
        if (r_m2_fz) begin
            w_res.map_x     = r_m2_dxn ? MAP_W'(MAP_LO) : MAP_W'(MAP_HI);
            w_res.map_y     = r_m2_dyn ? MAP_W'(MAP_LO) : MAP_W'(MAP_HI);
            w_res.saturated = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_ob[r_rp];

endmodule

[tb/radial_undistort_map_tb.sv]
// Self-checking testbench for the radial undistortion map: directed table plus random traffic.
`timescale 1ns / 100ps

module radial_undistort_map_tb;
    import rum_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     PIPE_DEPTH   = 42;
    localparam int     RANDOM_ITEMS = 850;
    localparam int     DRAIN_LIMIT  = 20000;
    localparam int     MAX_REPORTS  = 10;
    localparam longint WATCHDOG_NS  = 5_000_000;
    localparam int     COORD_MAX    = (1 << COORD_BITS) - 1;

    localparam longint      ONE_Q28   = 64'sd1 <<< NORM_FRAC;
    localparam logic [63:0] ONE_U28   = 64'd1 << NORM_FRAC;
    localparam logic [63:0] HALF_U28  = 64'd1 << (NORM_FRAC - 1);
    localparam logic [63:0] NORM_CLIP = 64'd1 << (NORM_FRAC + 1);
    localparam longint      MAP_HI    = (64'sd1 <<< (MAP_W - 1)) - 1;
    localparam longint      MAP_LO    = -MAP_HI - 1;

    localparam logic [MAP_W-1:0] SAT_HI_WORD = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic [MAP_W-1:0] SAT_LO_WORD = {1'b1, {(MAP_W-1){1'b0}}};

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} row_chk_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_in_word             pix;
        row_chk_t             chk;
        t_out_word            want;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_data;
    logic                 i_cfg_wr = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Register shadow used by the predictor.
    logic [CTR_W-1:0]          ctr_x = CENTER_X_RST;
    logic [CTR_W-1:0]          ctr_y = CENTER_Y_RST;
    logic signed [FOC_W-1:0]   foc_x = FOCAL_X_RST;
    logic signed [FOC_W-1:0]   foc_y = FOCAL_Y_RST;
    logic signed [COEFF_W-1:0] k1_coeff = COEFF_RST;

    t_out_word pending_maps[$];
    stim_row_t stim_rows[$];
    int        err_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    radial_undistort_map i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr    (i_cfg_wr),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] norm_axis(input longint d, input longint f, inout bit sat);
        logic [63:0] q;
        q = (mag(d) << NORM_FRAC) / mag(f);
        if (q > NORM_CLIP) begin
            q = NORM_CLIP;
            sat = 1'b1;
        end
        return q;
    endfunction

    function automatic longint clip_map(input longint v, inout bit sat);
        if (v > MAP_HI) begin
            sat = 1'b1;
            return MAP_HI;
        end
        if (v < MAP_LO) begin
            sat = 1'b1;
            return MAP_LO;
        end
        return v;
    endfunction

    // Scales one axis offset by the Q.28 factor, rounding half up, and adds the center back.
    function automatic longint scale_axis(input longint d, input longint ctr, input longint scale,
                                          inout bit sat);
        logic [63:0] a, b, m;
        longint      off;
        bit          neg;
        a = mag(d);
        b = mag(scale);
        neg = (d < 0) != (scale < 0);
        if (b != 0 && a > ((64'd1 << 63) / b)) begin
            sat = 1'b1;
            return neg ? MAP_LO : MAP_HI;
        end
        m = a * b;
        if (!neg)
            off = longint'((m + HALF_U28) >> NORM_FRAC);
        else if (m <= HALF_U28)
            off = 0;
        else
            off = -longint'((m - HALF_U28 + ONE_U28 - 1) >> NORM_FRAC);
        return clip_map(ctr + off, sat);
    endfunction

    // Returns 1 and the source coordinate when the block is expected to give one.
    function automatic bit predict_remap(input t_in_word pix, output t_out_word res);
        longint      px, py, cx, cy, fx, fy, k, dx, dy, kr, r2s, scale, mx, my;
        logic [63:0] nx, ny, r2;
        bit          sat;
        res = '0;
        sat = 1'b0;
        px = pix.pixel_x;
        py = pix.pixel_y;
        cx = ctr_x;
        cy = ctr_y;
        fx = foc_x;
        fy = foc_y;
        k = k1_coeff;
        dx = (px << FRAC_BITS) - cx;
        dy = (py << FRAC_BITS) - cy;
        if (k == 0)
            return 1'b0;
        if (fx == 0 || fy == 0) begin
            sat = 1'b1;
            mx = (dx >= 0) ? MAP_HI : MAP_LO;
            my = (dy >= 0) ? MAP_HI : MAP_LO;
        end else begin
            nx = norm_axis(dx, fx, sat);
            ny = norm_axis(dy, fy, sat);
            r2 = (nx * nx + ny * ny) >> NORM_FRAC;
            r2s = r2;
            kr = k * r2s;
            scale = ONE_Q28 - (kr >>> NORM_FRAC);
            mx = scale_axis(dx, cx, scale, sat);
            my = scale_axis(dy, cy, scale, sat);
        end
        res.map_x = MAP_W'(mx);
        res.map_y = MAP_W'(my);
        res.saturated = sat;
        return 1'b1;
    endfunction

    function automatic t_out_word map_word(input logic [MAP_W-1:0] x, input logic [MAP_W-1:0] y,
                                           input logic sat);
        t_out_word w;
        w.map_x = x;
        w.map_y = y;
        w.saturated = sat;
        return w;
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        stim_row_t r;
        r = '{kind: ROW_CFG, idx: idx, data: data, pix: '0, chk: CHK_NONE, want: '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_pix(input int px, input int py, input row_chk_t chk, input t_out_word want);
        stim_row_t r;
        r = '{kind: ROW_PIX, idx: '0, data: '0, pix: '0, chk: chk, want: want};
        r.pix.pixel_x = COORD_BITS'(px);
        r.pix.pixel_y = COORD_BITS'(py);
        stim_rows.push_back(r);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 25;
                recv_stall_pct = 46;
            end
            1: begin
                send_idle_pct = 46;
                recv_stall_pct = 25;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Drives one register write and mirrors it into the shadow; leaves the write enable high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X:     ctr_x = data[CTR_W-1:0];
            CFG_CENTER_Y:     ctr_y = data[CTR_W-1:0];
            CFG_FOCAL_X:      foc_x = data[FOC_W-1:0];
            CFG_FOCAL_Y:      foc_y = data[FOC_W-1:0];
            CFG_RADIAL_COEFF: k1_coeff = data[COEFF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Offers one word and returns at the falling edge after it was taken, valid still high.
    task automatic send_pixel(input t_in_word pix, input row_chk_t chk, input t_out_word want);
        t_out_word w;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= pix;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        case (chk)
            CHK_MODEL: if (predict_remap(pix, w)) pending_maps.push_back(w);
            CHK_WORD:  pending_maps.push_back(want);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Registers change only with the pipeline empty; words with a zero coefficient leave no
    // trace in the queue, so a full pipeline depth is waited out as well.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 8) @(negedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [CTR_W-1:0] ctr);
        int r;
        int c;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) != 0) ? COORD_BITS'(COORD_MAX) : '0;
        if (r < 30) begin
            c = $urandom_range(0, 128);
            c = c - 64 + int'(ctr >> FRAC_BITS);
            if (c < 0)
                c = 0;
            if (c > COORD_MAX)
                c = COORD_MAX;
            return COORD_BITS'(c);
        end
        return COORD_BITS'($urandom_range(0, COORD_MAX));
    endfunction

    // Picks a new setting of every register: mostly plausible optics, some raw and extreme values.
    task automatic roll_setting();
        logic [CFG_W-1:0]          data;
        logic signed [FOC_W-1:0]   f;
        logic signed [COEFF_W-1:0] k;
        int                        r;
        for (int axis = 0; axis < 2; axis++) begin
            data = $urandom;
            r = $urandom_range(0, 99);
            if (r < 15)
                data[CTR_W-1:0] = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else if (r >= 35)
                data[CTR_W-1:0] = {COORD_BITS'($urandom_range(0, COORD_MAX)),
                                   FRAC_BITS'($urandom_range(0, 255))};
            write_reg((axis == 0) ? CFG_CENTER_X : CFG_CENTER_Y, data);
        end
        for (int axis = 0; axis < 2; axis++) begin
            data = $urandom;
            r = $urandom_range(0, 99);
            if (r < 15) begin
                case ($urandom_range(0, 4))
                    0: f = '0;
                    1: f = 1;
                    2: f = -1;
                    3: f = {1'b0, {(FOC_W-1){1'b1}}};
                    default: f = {1'b1, {(FOC_W-1){1'b0}}};
                endcase
                data[FOC_W-1:0] = f;
            end else if (r >= 35) begin
                f = FOC_W'($urandom_range(64 << FRAC_BITS, 8000 << FRAC_BITS));
                if ($urandom_range(0, 4) == 0)
                    f = -f;
                data[FOC_W-1:0] = f;
            end
            write_reg((axis == 0) ? CFG_FOCAL_X : CFG_FOCAL_Y, data);
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            k = '0;
        else if (r < 20) begin
            case ($urandom_range(0, 3))
                0: k = 1;
                1: k = -1;
                2: k = 32'sh7FFF_FFFF;
                default: k = 32'sh8000_0000;
            endcase
        end else if (r < 40)
            k = $urandom;
        else begin
            k = $urandom_range(0, 1 << (NORM_FRAC - 1));
            if ($urandom_range(0, 1) != 0)
                k = -k;
        end
        write_reg(CFG_RADIAL_COEFF, k);
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_RADIAL_COEFF) + 1,
                                                (1 << CFG_IDX_W) - 1)), $urandom);
    endtask

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_maps.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected word x=%0d y=%0d sat=%0d", $realtime,
                             o_out_data.map_x, o_out_data.map_y, o_out_data.saturated);
            end else begin
                exp_w = pending_maps.pop_front();
                if (o_out_data.map_x !== exp_w.map_x || o_out_data.map_y !== exp_w.map_y ||
                    o_out_data.saturated !== exp_w.saturated) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: expected x=%0d y=%0d sat=%0d, got x=%0d y=%0d sat=%0d",
                                 $realtime, exp_w.map_x, exp_w.map_y, exp_w.saturated,
                                 o_out_data.map_x, o_out_data.map_y, o_out_data.saturated);
                end
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("radial_undistort_map: mismatch");
        $finish;
    end

    initial begin
        stim_row_t row;
        row_kind_t prev;
        int        mapped_items;
        int        n;
        int        guard;
        bit        counts;
        t_in_word  pix;

        // With the reset coefficient of zero nothing comes out.
        add_pix(0, 0, CHK_NONE, '0);
        add_pix(COORD_MAX, COORD_MAX, CHK_NONE, '0);
        // Smallest coefficient; the principal point maps onto itself.
        add_cfg(CFG_RADIAL_COEFF, 32'd1);
        add_pix(320, 240, CHK_WORD, map_word(MAP_W'(81920), MAP_W'(61440), 1'b0));
        add_pix(0, 0, CHK_MODEL, '0);
        add_pix(COORD_MAX, 0, CHK_MODEL, '0);
        add_pix(0, COORD_MAX, CHK_MODEL, '0);
        add_pix(COORD_MAX, COORD_MAX, CHK_MODEL, '0);
        // Coefficient extremes.
        add_cfg(CFG_RADIAL_COEFF, 32'h7FFF_FFFF);
        add_pix(0, 0, CHK_MODEL, '0);
        add_pix(COORD_MAX, COORD_MAX, CHK_MODEL, '0);
        add_pix(320, 240, CHK_WORD, map_word(MAP_W'(81920), MAP_W'(61440), 1'b0));
        add_cfg(CFG_RADIAL_COEFF, 32'h8000_0000);
        add_pix(0, 0, CHK_MODEL, '0);
        add_pix(COORD_MAX, COORD_MAX, CHK_MODEL, '0);
        // A zero focal length drives both maps to the rail picked by the sign of the offset.
        add_cfg(CFG_FOCAL_X, 32'd0);
        add_pix(0, COORD_MAX, CHK_WORD, map_word(SAT_LO_WORD, SAT_HI_WORD, 1'b1));
        add_pix(COORD_MAX, 0, CHK_WORD, map_word(SAT_HI_WORD, SAT_LO_WORD, 1'b1));
        add_pix(320, 240, CHK_WORD, map_word(SAT_HI_WORD, SAT_HI_WORD, 1'b1));
        add_cfg(CFG_FOCAL_X, 32'd256000);
        add_cfg(CFG_FOCAL_Y, 32'd0);
        add_pix(0, 0, CHK_WORD, map_word(SAT_LO_WORD, SAT_LO_WORD, 1'b1));
        // A tiny focal length pushes the normalized coordinate past its clip.
        add_cfg(CFG_FOCAL_X, 32'd1);
        add_cfg(CFG_FOCAL_Y, -32'sd16777216);
        add_pix(COORD_MAX, COORD_MAX, CHK_MODEL, '0);
        add_pix(0, 0, CHK_MODEL, '0);
        // Center and focal extremes.
        add_cfg(CFG_CENTER_X, 32'd0);
        add_cfg(CFG_CENTER_Y, 32'd2097151);
        add_cfg(CFG_FOCAL_X, 32'd16777215);
        add_pix(0, 0, CHK_MODEL, '0);
        add_pix(COORD_MAX, COORD_MAX, CHK_MODEL, '0);
        // Writes past the last register must leave every register alone.
        for (int j = int'(CFG_RADIAL_COEFF) + 1; j < (1 << CFG_IDX_W); j++)
            add_cfg(CFG_IDX_W'(j), $urandom);
        add_pix(1000, 3000, CHK_MODEL, '0);

        set_idle(0);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        prev = ROW_PIX;
        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.kind == ROW_CFG) begin
                if (prev == ROW_PIX)
                    quiesce();
                write_reg(row.idx, row.data);
            end else begin
                if (prev == ROW_CFG)
                    i_cfg_wr <= 1'b0;
                send_pixel(row.pix, row.chk, row.want);
            end
            prev = row.kind;
        end

        // Random phases, each under a fresh register setting; words sent with a zero
        // coefficient give nothing and do not count.
        mapped_items = 0;
        while (mapped_items < RANDOM_ITEMS) begin
            set_idle(mapped_items * 3 / RANDOM_ITEMS);
            quiesce();
            roll_setting();
            i_cfg_wr <= 1'b0;
            counts = (k1_coeff != 0);
            n = counts ? $urandom_range(40, 100) : 20;
            repeat (n) begin
                pix.pixel_x = pick_coord(ctr_x);
                pix.pixel_y = pick_coord(ctr_y);
                send_pixel(pix, CHK_MODEL, '0);
                if (counts)
                    mapped_items++;
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_maps.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 8) @(negedge i_clk);
        if (pending_maps.size() != 0) begin
            err_count += pending_maps.size();
            $display("%0d expected words never arrived", pending_maps.size());
        end
        if (err_count == 0)
            $display("radial_undistort_map: match");
        else
            $display("radial_undistort_map: mismatch");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rum_pkg.sv
hw/rtl/radial_undistort_map.sv
tb/radial_undistort_map_tb.sv
